// ===== rtl/cbcr_pkg.sv =====
// Shared widths, context type and saturation helpers for the circle/box resolver.
`default_nettype none
package cbcr_pkg;
    localparam int unsigned DataW   = 32;
    localparam int unsigned RadW    = 28;
    localparam int unsigned DeltaW  = RadW + 1;
    localparam int unsigned SqW     = 2 * RadW;
    localparam int unsigned SqStg   = RadW;
    localparam int unsigned FracW   = 16;
    localparam int unsigned QuoW    = FracW + 1;
    localparam int unsigned AddrW   = 3;
    localparam logic        RegRadius   = 1'b0;
    localparam logic [RadW-1:0] RadiusReset = 28'd655360;

    typedef struct packed {
        logic signed [DataW-1:0]  x;
        logic signed [DataW-1:0]  y;
        logic signed [DataW-1:0]  vx;
        logic signed [DataW-1:0]  vy;
        logic signed [DeltaW-1:0] dx;
        logic signed [DeltaW-1:0] dy;
        logic signed [DataW-1:0]  alt_x;
        logic signed [DataW-1:0]  alt_y;
        logic signed [DataW-1:0]  alt_vx;
        logic signed [DataW-1:0]  alt_vy;
        logic                     hit;
        logic                     outside;
    } t_ctx;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[DataW-1:0];
    endfunction

    function automatic logic signed [DataW-1:0] neg_sat(input logic signed [DataW-1:0] v);
        logic signed [39:0] w;
        w = 40'(v);
        return sat32(-w);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/cbcr_front.sv =====
// Front stages: clamp, contact test, squares, inside-box push-out.
`default_nettype none
module cbcr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [31:0]            i_x,
    input  wire logic signed [31:0]            i_y,
    input  wire logic signed [31:0]            i_vx,
    input  wire logic signed [31:0]            i_vy,
    input  wire logic signed [31:0]            i_l,
    input  wire logic signed [31:0]            i_t,
    input  wire logic signed [31:0]            i_r,
    input  wire logic signed [31:0]            i_b,
    input  wire logic [cbcr_pkg::RadW-1:0]     i_radius,
    input  wire logic [cbcr_pkg::SqW-1:0]      i_r2,
    output logic                               o_valid,
    output cbcr_pkg::t_ctx                     o_ctx,
    output logic [cbcr_pkg::SqW-1:0]           o_d2
);
    import cbcr_pkg::*;

    // stage 1
    logic signed [31:0] cx, cy;
    logic signed [32:0] n_dx, n_dy;
    logic               r1_v;
    logic signed [31:0] r1_x, r1_y, r1_vx, r1_vy, r1_l, r1_t, r1_r, r1_b;
    logic signed [32:0] r1_dx, r1_dy;

    assign cx   = (i_x < i_l) ? i_l : ((i_x > i_r) ? i_r : i_x);
    assign cy   = (i_y < i_t) ? i_t : ((i_y > i_b) ? i_b : i_y);
    assign n_dx = 33'(i_x) - 33'(cx);
    assign n_dy = 33'(i_y) - 33'(cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x <= i_x;  r1_y <= i_y;  r1_vx <= i_vx; r1_vy <= i_vy;
            r1_l <= i_l;  r1_t <= i_t;  r1_r <= i_r;   r1_b <= i_b;
            r1_dx <= n_dx; r1_dy <= n_dy;
        end
    end

    // stage 2
    logic signed [33:0] rad_s;
    logic               near, in_box;
    logic [32:0]        adx, ady;
    logic signed [32:0] dl, dr, dt, db;
    logic               sel_l, sel_r, sel_t;
    logic signed [31:0] ins_x, ins_y, ins_vx, ins_vy;

    assign rad_s  = $signed({6'b0, i_radius});
    assign near   = (34'(r1_dx) <= rad_s) && (34'(r1_dx) >= -rad_s) &&
                    (34'(r1_dy) <= rad_s) && (34'(r1_dy) >= -rad_s);
    assign in_box = (r1_x >= r1_l) && (r1_x <= r1_r) && (r1_y >= r1_t) && (r1_y <= r1_b);
    assign adx    = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
    assign ady    = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);
    assign dl     = 33'(r1_x) - 33'(r1_l);
    assign dr     = 33'(r1_r) - 33'(r1_x);
    assign dt     = 33'(r1_y) - 33'(r1_t);
    assign db     = 33'(r1_b) - 33'(r1_y);
    // nearest side, ties in order left, right, top, bottom
    assign sel_l  = (dl <= dr) && (dl <= dt) && (dl <= db);
    assign sel_r  = !sel_l && (dr <= dt) && (dr <= db);
    assign sel_t  = !sel_l && !sel_r && (dt <= db);

    always_comb begin
        ins_x  = r1_x;
        ins_y  = r1_y;
        ins_vx = r1_vx;
        ins_vy = r1_vy;
        if (sel_l) begin
            ins_x  = sat32(40'(r1_l) - 40'($signed({1'b0, i_radius})));
            ins_vx = r1_vx[31] ? r1_vx : neg_sat(r1_vx);
        end else if (sel_r) begin
            ins_x  = sat32(40'(r1_r) + 40'($signed({1'b0, i_radius})));
            ins_vx = r1_vx[31] ? neg_sat(r1_vx) : r1_vx;
        end else if (sel_t) begin
            ins_y  = sat32(40'(r1_t) - 40'($signed({1'b0, i_radius})));
            ins_vy = r1_vy[31] ? r1_vy : neg_sat(r1_vy);
        end else begin
            ins_y  = sat32(40'(r1_b) + 40'($signed({1'b0, i_radius})));
            ins_vy = r1_vy[31] ? neg_sat(r1_vy) : r1_vy;
        end
    end

    logic               r2_v, r2_near, r2_inside;
    logic signed [31:0] r2_x, r2_y, r2_vx, r2_vy;
    logic signed [31:0] r2_ix, r2_iy, r2_ivx, r2_ivy;
    logic signed [DeltaW-1:0] r2_dx, r2_dy;
    logic [SqW-1:0]     r2_sqx, r2_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_near   <= near;
            r2_inside <= in_box;
            r2_x <= r1_x; r2_y <= r1_y; r2_vx <= r1_vx; r2_vy <= r1_vy;
            r2_ix <= ins_x; r2_iy <= ins_y; r2_ivx <= ins_vx; r2_ivy <= ins_vy;
            r2_dx  <= r1_dx[DeltaW-1:0];
            r2_dy  <= r1_dy[DeltaW-1:0];
            r2_sqx <= adx[RadW-1:0] * adx[RadW-1:0];
            r2_sqy <= ady[RadW-1:0] * ady[RadW-1:0];
        end
    end

    // stage 3
    logic [SqW:0] d2;
    logic         hit;
    t_ctx         n_ctx;

    assign d2  = {1'b0, r2_sqx} + {1'b0, r2_sqy};
    assign hit = r2_near && (d2 <= {1'b0, i_r2});

    always_comb begin
        n_ctx.x       = r2_x;
        n_ctx.y       = r2_y;
        n_ctx.vx      = r2_vx;
        n_ctx.vy      = r2_vy;
        n_ctx.dx      = r2_dx;
        n_ctx.dy      = r2_dy;
        n_ctx.hit     = hit;
        n_ctx.outside = hit && !r2_inside;
        n_ctx.alt_x   = (hit && r2_inside) ? r2_ix  : r2_x;
        n_ctx.alt_y   = (hit && r2_inside) ? r2_iy  : r2_y;
        n_ctx.alt_vx  = (hit && r2_inside) ? r2_ivx : r2_vx;
        n_ctx.alt_vy  = (hit && r2_inside) ? r2_ivy : r2_vy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctx <= n_ctx;
            o_d2  <= d2[SqW-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cbcr_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module cbcr_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire cbcr_pkg::t_ctx            i_ctx,
    input  wire logic [cbcr_pkg::SqW-1:0]  i_d2,
    output logic                           o_valid,
    output cbcr_pkg::t_ctx                 o_ctx,
    output logic [cbcr_pkg::RadW-1:0]      o_dist
);
    import cbcr_pkg::*;
    localparam int unsigned RemW = RadW + 1;

    logic            s_v    [SqStg+1];
    t_ctx            s_ctx  [SqStg+1];
    logic [SqW-1:0]  s_n    [SqStg+1];
    logic [RemW-1:0] s_rem  [SqStg+1];
    logic [RadW-1:0] s_root [SqStg+1];

    assign s_v[0]    = i_valid;
    assign s_ctx[0]  = i_ctx;
    assign s_n[0]    = i_d2;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    for (genvar i = 0; i < SqStg; i++) begin : g_stage
        logic [RemW+1:0] cur, trial, diff;
        logic            ge;
        logic            r_v;
        t_ctx            r_ctx;
        logic [SqW-1:0]  r_n;
        logic [RemW-1:0] r_rem;
        logic [RadW-1:0] r_root;

        assign cur   = {s_rem[i], s_n[i][SqW-1 -: 2]};
        assign trial = {1'b0, s_root[i], 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx  <= s_ctx[i];
                r_n    <= {s_n[i][SqW-3:0], 2'b00};
                r_rem  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
                r_root <= {s_root[i][RadW-2:0], ge};
            end
        end

        assign s_v[i+1]    = r_v;
        assign s_ctx[i+1]  = r_ctx;
        assign s_n[i+1]    = r_n;
        assign s_rem[i+1]  = r_rem;
        assign s_root[i+1] = r_root;
    end

    assign o_valid = s_v[SqStg];
    assign o_ctx   = s_ctx[SqStg];
    assign o_dist  = s_root[SqStg];
endmodule
`default_nettype wire

// ===== rtl/cbcr_div.sv =====
// Pipelined restoring divider for the contact normal, two lanes, one bit per stage.
`default_nettype none
module cbcr_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire cbcr_pkg::t_ctx             i_ctx,
    input  wire logic [cbcr_pkg::RadW-1:0]  i_dist,
    output logic                            o_valid,
    output cbcr_pkg::t_ctx                  o_ctx,
    output logic [cbcr_pkg::RadW-1:0]      o_dist,
    output logic [cbcr_pkg::QuoW-1:0]      o_qx,
    output logic [cbcr_pkg::QuoW-1:0]      o_qy
);
    import cbcr_pkg::*;

    logic                    s_v    [QuoW+1];
    t_ctx                    s_ctx  [QuoW+1];
    logic [RadW-1:0]         s_dist [QuoW+1];
    logic [1:0][RadW-1:0]    s_rem  [QuoW+1];
    logic [1:0][QuoW-1:0]    s_bits [QuoW+1];
    logic [1:0][QuoW-1:0]    s_q    [QuoW+1];
    logic [DeltaW-1:0]       adx, ady;

    // |d| * 2^16 split into the part above the quotient width and the rest
    assign adx = i_ctx.dx[DeltaW-1] ? DeltaW'(-i_ctx.dx) : DeltaW'(i_ctx.dx);
    assign ady = i_ctx.dy[DeltaW-1] ? DeltaW'(-i_ctx.dy) : DeltaW'(i_ctx.dy);

    assign s_v[0]       = i_valid;
    assign s_ctx[0]     = i_ctx;
    assign s_dist[0]    = i_dist;
    assign s_rem[0][0]  = {1'b0, adx[RadW-1:1]};
    assign s_rem[0][1]  = {1'b0, ady[RadW-1:1]};
    assign s_bits[0][0] = {adx[0], {FracW{1'b0}}};
    assign s_bits[0][1] = {ady[0], {FracW{1'b0}}};
    assign s_q[0]       = '0;

    for (genvar i = 0; i < QuoW; i++) begin : g_stage
        logic                 r_v;
        t_ctx                 r_ctx;
        logic [RadW-1:0]      r_dist;
        logic [1:0][RadW-1:0] r_rem;
        logic [1:0][QuoW-1:0] r_bits;
        logic [1:0][QuoW-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx  <= s_ctx[i];
                r_dist <= s_dist[i];
            end
        end

        for (genvar k = 0; k < 2; k++) begin : g_lane
            logic [RadW:0] cur, diff;
            logic          ge;

            assign cur  = {s_rem[i][k], s_bits[i][k][QuoW-1]};
            assign diff = cur - {1'b0, s_dist[i]};
            assign ge   = cur >= {1'b0, s_dist[i]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? diff[RadW-1:0] : cur[RadW-1:0];
                    r_bits[k] <= {s_bits[i][k][QuoW-2:0], 1'b0};
                    r_q[k]    <= {s_q[i][k][QuoW-2:0], ge};
                end
            end
        end

        assign s_v[i+1]    = r_v;
        assign s_ctx[i+1]  = r_ctx;
        assign s_dist[i+1] = r_dist;
        assign s_rem[i+1]  = r_rem;
        assign s_bits[i+1] = r_bits;
        assign s_q[i+1]    = r_q;
    end

    assign o_valid = s_v[QuoW];
    assign o_ctx   = s_ctx[QuoW];
    assign o_dist  = s_dist[QuoW];
    assign o_qx    = s_q[QuoW][0];
    assign o_qy    = s_q[QuoW][1];
endmodule
`default_nettype wire

// ===== rtl/cbcr_resp.sv =====
// Response stages: push-out along the normal, velocity reflection, final select.
`default_nettype none
module cbcr_resp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire cbcr_pkg::t_ctx             i_ctx,
    input  wire logic [cbcr_pkg::RadW-1:0]  i_dist,
    input  wire logic [cbcr_pkg::QuoW-1:0]  i_qx,
    input  wire logic [cbcr_pkg::QuoW-1:0]  i_qy,
    input  wire logic [cbcr_pkg::RadW-1:0]  i_radius,
    output logic                            o_valid,
    output logic signed [31:0]              o_x,
    output logic signed [31:0]              o_y,
    output logic signed [31:0]              o_vx,
    output logic signed [31:0]              o_vy,
    output logic                            o_hit
);
    import cbcr_pkg::*;

    // stage 1: signed normal, penetration, first products
    logic signed [QuoW:0] nx, ny;
    logic signed [RadW:0] pen;

    assign nx  = i_ctx.dx[DeltaW-1] ? -$signed({1'b0, i_qx}) : $signed({1'b0, i_qx});
    assign ny  = i_ctx.dy[DeltaW-1] ? -$signed({1'b0, i_qy}) : $signed({1'b0, i_qy});
    assign pen = $signed({1'b0, i_radius - i_dist});

    logic                 r1_v, r1_dz;
    t_ctx                 r1_ctx;
    logic signed [QuoW:0] r1_nx, r1_ny;
    logic signed [46:0]   r1_p1, r1_p2;
    logic signed [49:0]   r1_p3, r1_p4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctx <= i_ctx;
            r1_dz  <= (i_dist == '0);
            r1_nx  <= nx;
            r1_ny  <= ny;
            r1_p1  <= nx * pen;
            r1_p2  <= ny * pen;
            r1_p3  <= i_ctx.vx * nx;
            r1_p4  <= i_ctx.vy * ny;
        end
    end

    // stage 2: truncate toward zero, new position, normal velocity
    logic signed [46:0] a1, a2;
    logic signed [49:0] a3, a4;
    logic signed [34:0] vn;

    assign a1 = r1_p1 + $signed({31'b0, {FracW{r1_p1[46]}}});
    assign a2 = r1_p2 + $signed({31'b0, {FracW{r1_p2[46]}}});
    assign a3 = r1_p3 + $signed({34'b0, {FracW{r1_p3[49]}}});
    assign a4 = r1_p4 + $signed({34'b0, {FracW{r1_p4[49]}}});
    assign vn = 35'($signed(a3[49:16])) + 35'($signed(a4[49:16]));

    logic                 r2_v, r2_dz;
    t_ctx                 r2_ctx;
    logic signed [QuoW:0] r2_nx, r2_ny;
    logic signed [31:0]   r2_px, r2_py;
    logic signed [35:0]   r2_vn2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ctx <= r1_ctx;
            r2_dz  <= r1_dz;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_px  <= sat32(40'(r1_ctx.x) + 40'($signed(a1[46:16])));
            r2_py  <= sat32(40'(r1_ctx.y) + 40'($signed(a2[46:16])));
            r2_vn2 <= {vn, 1'b0};
        end
    end

    // stage 3: reflection products
    logic                 r3_v, r3_dz;
    t_ctx                 r3_ctx;
    logic signed [31:0]   r3_px, r3_py;
    logic signed [53:0]   r3_qx, r3_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ctx <= r2_ctx;
            r3_dz  <= r2_dz;
            r3_px  <= r2_px;
            r3_py  <= r2_py;
            r3_qx  <= r2_vn2 * r2_nx;
            r3_qy  <= r2_vn2 * r2_ny;
        end
    end

    // stage 4: reflected velocity and final select
    logic signed [53:0] b1, b2;
    logic signed [31:0] rvx, rvy;
    logic signed [31:0] f_x, f_y, f_vx, f_vy;

    assign b1  = r3_qx + $signed({38'b0, {FracW{r3_qx[53]}}});
    assign b2  = r3_qy + $signed({38'b0, {FracW{r3_qy[53]}}});
    assign rvx = sat32(40'(r3_ctx.vx) - 40'($signed(b1[53:16])));
    assign rvy = sat32(40'(r3_ctx.vy) - 40'($signed(b2[53:16])));

    always_comb begin
        f_x  = r3_ctx.alt_x;
        f_y  = r3_ctx.alt_y;
        f_vx = r3_ctx.alt_vx;
        f_vy = r3_ctx.alt_vy;
        if (r3_ctx.outside) begin
            if (r3_dz) begin
                // center on the box outline with zero distance: flip vx only
                f_x  = r3_ctx.x;
                f_y  = r3_ctx.y;
                f_vx = neg_sat(r3_ctx.vx);
                f_vy = r3_ctx.vy;
            end else begin
                f_x  = r3_px;
                f_y  = r3_py;
                f_vx = rvx;
                f_vy = rvy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= f_x;
            o_y   <= f_y;
            o_vx  <= f_vx;
            o_vy  <= f_vy;
            o_hit <= r3_ctx.hit;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/circle_box_collision_resolve_top.sv =====
// Top level of the circle versus axis-aligned box collision resolver.
// Pipeline: 3 front, 28 square root, 17 divider and 4 response stages, then
//   1 output register; results wait only while the output is stalled.
// Throughput: one transaction per cycle unless stalled; flat register stages.
// Reset (synchronous, active low) empties all stages and loads radius 10.0.
`default_nettype none
module circle_box_collision_resolve_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input transactions
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // ball_x, ball_y, vel_x, vel_y, box_left, box_top, box_right, box_bottom
    input  wire logic [255:0]                  s_axis_tdata,
    // result transactions
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // new_x, new_y, new_vx, new_vy
    output logic [127:0]                       m_axis_tdata,
    // hit
    output logic [0:0]                         m_axis_tuser,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cbcr_pkg::AddrW-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import cbcr_pkg::*;

    // ---------------------------------------------------------------
    // Configuration: one register, radius, at byte address 0.
    // ---------------------------------------------------------------
    logic [RadW-1:0] r_radius;
    logic [SqW-1:0]  r_r2;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == RegRadius) ? {4'b0, r_radius} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RadiusReset;
        end else if (cfg_wr && (paddr[2] == RegRadius)) begin
            r_radius <= pwdata[RadW-1:0];
        end
    end

    // radius squared for the contact compare, refreshed every cycle; the user must
    // change config only while the pipe is empty, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    // ---------------------------------------------------------------
    // Flow control: the whole pipe advances together. It also advances
    // while a result waits in the output register, as long as the last
    // stage is empty, so a finished result does not block new input.
    // ---------------------------------------------------------------
    logic out_load, en;
    logic last_v;
    logic signed [31:0] last_x, last_y, last_vx, last_vy;
    logic last_hit;

    assign out_load      = !m_axis_tvalid || m_axis_tready;
    assign en            = out_load || !last_v;
    assign s_axis_tready = en;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic            fr_v;
    t_ctx            fr_ctx;
    logic [SqW-1:0]  fr_d2;
    logic            sq_v;
    t_ctx            sq_ctx;
    logic [RadW-1:0] sq_dist;
    logic            dv_v;
    t_ctx            dv_ctx;
    logic [RadW-1:0] dv_dist;
    logic [QuoW-1:0] dv_qx, dv_qy;

    cbcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_x      ($signed(s_axis_tdata[31:0])),
        .i_y      ($signed(s_axis_tdata[63:32])),
        .i_vx     ($signed(s_axis_tdata[95:64])),
        .i_vy     ($signed(s_axis_tdata[127:96])),
        .i_l      ($signed(s_axis_tdata[159:128])),
        .i_t      ($signed(s_axis_tdata[191:160])),
        .i_r      ($signed(s_axis_tdata[223:192])),
        .i_b      ($signed(s_axis_tdata[255:224])),
        .i_radius (r_radius),
        .i_r2     (r_r2),
        .o_valid  (fr_v),
        .o_ctx    (fr_ctx),
        .o_d2     (fr_d2)
    );

    cbcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_v),
        .i_ctx   (fr_ctx),
        .i_d2    (fr_d2),
        .o_valid (sq_v),
        .o_ctx   (sq_ctx),
        .o_dist  (sq_dist)
    );

    cbcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_ctx   (sq_ctx),
        .i_dist  (sq_dist),
        .o_valid (dv_v),
        .o_ctx   (dv_ctx),
        .o_dist  (dv_dist),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy)
    );

    cbcr_resp u_resp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (dv_v),
        .i_ctx    (dv_ctx),
        .i_dist   (dv_dist),
        .i_qx     (dv_qx),
        .i_qy     (dv_qy),
        .i_radius (r_radius),
        .o_valid  (last_v),
        .o_x      (last_x),
        .o_y      (last_y),
        .o_vx     (last_vx),
        .o_vy     (last_vy),
        .o_hit    (last_hit)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic         r_out_v;
    logic [127:0] r_out_data;
    logic         r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= last_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {last_vy, last_vx, last_y, last_x};
            r_out_hit  <= last_hit;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;
endmodule
`default_nettype wire

// ===== rtl/cbcr_checker.sv =====
// Port-level checker for the collision resolver, bound to the top level.
`default_nettype none
module cbcr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_axis_tready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [127:0]                m_axis_tdata,
    input wire logic [0:0]                  m_axis_tuser,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [cbcr_pkg::AddrW-1:0]  paddr,
    input wire logic [31:0]                 pwdata,
    input wire logic [31:0]                 prdata,
    input wire logic                        pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
        else $error("input blocked while output side can move");

    a_cfg_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> !paddr[2] |-> prdata[27:0] == $past(pwdata[27:0]))
        else $error("radius readback mismatch");
endmodule

bind circle_box_collision_resolve_top cbcr_checker u_cbcr_checker (.*);
`default_nettype wire

// ===== tb/sv/circle_box_collision_resolve_checker.sv =====
// Result checker for the circle/box resolver: predicts each result and compares it.
module circle_box_collision_resolve_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [cbcr_pkg::AddrW-1:0] paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        hit;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [31:0] y;
        logic [31:0] x;
    } t_resp;

    t_resp           resp_q[$];
    logic [27:0]     radius_q;

    assign o_pending = resp_q.size();

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mulq(input longint a, input longint b);
        return (a * b) / 65536;
    endfunction

    function automatic longint absl(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clampc(input longint c, input longint lo, input longint hi);
        if (c < lo) return lo;
        if (c > hi) return hi;
        return c;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic t_resp resolve(input logic [255:0] d, input logic [27:0] rad_in);
        longint x, y, vx, vy, l, t, r, b, rad, px, py, pvx, pvy;
        longint dx, dy, dl, dr, dt, db, m, dlen, nx, ny, pen, vn;
        logic [63:0] d2, r2;
        logic hit;
        t_resp res;
        x  = longint'($signed(d[31:0]));
        y  = longint'($signed(d[63:32]));
        vx = longint'($signed(d[95:64]));
        vy = longint'($signed(d[127:96]));
        l  = longint'($signed(d[159:128]));
        t  = longint'($signed(d[191:160]));
        r  = longint'($signed(d[223:192]));
        b  = longint'($signed(d[255:224]));
        rad = longint'({36'd0, rad_in});
        px = x; py = y; pvx = vx; pvy = vy; hit = 1'b0;
        dx = x - clampc(x, l, r);
        dy = y - clampc(y, t, b);
        if (absl(dx) <= rad && absl(dy) <= rad) begin
            d2 = dx * dx + dy * dy;
            r2 = rad * rad;
            if (d2 <= r2) begin
                hit = 1'b1;
                if (x >= l && x <= r && y >= t && y <= b) begin
                    dl = x - l; dr = r - x; dt = y - t; db = b - y;
                    m = dl;
                    if (dr < m) m = dr;
                    if (dt < m) m = dt;
                    if (db < m) m = db;
                    if (m == dl) begin
                        px = l - rad; pvx = -absl(vx);
                    end else if (m == dr) begin
                        px = r + rad; pvx = absl(vx);
                    end else if (m == dt) begin
                        py = t - rad; pvy = -absl(vy);
                    end else begin
                        py = b + rad; pvy = absl(vy);
                    end
                end else begin
                    dlen = longint'(isqrt(d2));
                    if (dlen == 0) begin
                        pvx = -vx;
                    end else begin
                        nx  = (dx * 65536) / dlen;
                        ny  = (dy * 65536) / dlen;
                        pen = rad - dlen;
                        px  = x + mulq(nx, pen);
                        py  = y + mulq(ny, pen);
                        vn  = mulq(vx, nx) + mulq(vy, ny);
                        pvx = vx - mulq(2 * vn, nx);
                        pvy = vy - mulq(2 * vn, ny);
                    end
                end
            end
        end
        res.x = 32'(sat(px));
        res.y = 32'(sat(py));
        res.vx = 32'(sat(pvx));
        res.vy = 32'(sat(pvy));
        res.hit = hit;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_resp got, want;
        if (!i_rst_n) begin
            radius_q     <= cbcr_pkg::RadiusReset;
            o_fail_count <= 0;
            resp_q.delete();
        end else begin
            // radius write lands at the access phase
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                radius_q <= pwdata[27:0];
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(resolve(s_axis_tdata, radius_q));
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata};
                if (resp_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result transaction %h", got);
                end else begin
                    want = resp_q.pop_front();
                    if (got !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display({"mismatch: exp x=%h y=%h vx=%h vy=%h hit=%b",
                                      " got x=%h y=%h vx=%h vy=%h hit=%b"},
                                want.x, want.y, want.vx, want.vy, want.hit,
                                got.x, got.y, got.vx, got.vy, got.hit);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/circle_box_collision_resolve_top_tb.sv =====
// Stimulus and verdict for the circle/box resolver testbench.
module circle_box_collision_resolve_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 53;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;   // ball_x, ball_y, vel_x, vel_y, left, top, right, bottom
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // new_x, new_y, new_vx, new_vy
    logic [0:0]   m_axis_tuser;        // hit
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [cbcr_pkg::AddrW-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circle_box_collision_resolve_top dut (.*);

    circle_box_collision_resolve_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stall before each accepted result transaction.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    // Radius register write: setup then access phase.
    task automatic write_radius(input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= '0; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // tvalid stays high between back-to-back transactions
    task automatic send_item(input logic [255:0] d, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk iff s_axis_tready);
    endtask

    task automatic send_box(input int x, y, vx, vy, l, t, r, b, input int gap);
        send_item({b, r, t, l, vy, vx, y, x}, gap);
    endtask

    // Idle point: all results in, plus pipeline slack.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (Latency + 5) @(posedge i_clk);
    endtask

    function automatic int rnd_coord(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Circle near a well-formed box so contact paths dominate.
    task automatic random_near(input int gap);
        int l, t, w, h, x, y, vx, vy;
        l = rnd_coord(100 << 16);
        t = rnd_coord(100 << 16);
        w = $urandom_range(0, 40 << 16);
        h = $urandom_range(0, 40 << 16);
        x = l + int'($urandom_range(0, w + (30 << 16))) - (15 << 16);
        y = t + int'($urandom_range(0, h + (30 << 16))) - (15 << 16);
        vx = ($urandom_range(0, 9) == 0) ? $urandom() : rnd_coord(20 << 16);
        vy = ($urandom_range(0, 9) == 0) ? $urandom() : rnd_coord(20 << 16);
        send_box(x, y, vx, vy, l, t, l + w, t + h, gap);
    endtask

    initial begin
        int gap;
        int radii[4] = '{0, 655360, 3 << 16, 32'h0FFF_FFFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset radius of 10.0
        send_box(0, 0, 5 << 16, 3 << 16, 1 << 16, -10 << 16, 20 << 16, 10 << 16, 0);  // left of box
        send_box(20 << 16, 0, 1, 2, 0, -10 << 16, 20 << 16, 10 << 16, 0);             // right edge
        send_box(10 << 16, -9 << 16, 1, -7, 0, -10 << 16, 20 << 16, 10 << 16, 0);     // top
        send_box(10 << 16, 9 << 16, 1, 7, 0, -10 << 16, 20 << 16, 10 << 16, 0);       // bottom
        send_box(-5 << 16, 0, 32'h8000_0000, 32'h8000_0000, 0, -1 << 16, 4 << 16,
            1 << 16, 0);                                                               // normal, min vel
        send_box(-10 << 16, 0, 3 << 16, 0, 0, 0, 4 << 16, 4 << 16, 0);                // grazing touch
        send_box(-10 << 16, -1, 3 << 16, 0, 0, 0, 4 << 16, 4 << 16, 0);               // just missing
        send_box(-8 << 16, -8 << 16, 2 << 16, 2 << 16, 0, 0, 4 << 16, 4 << 16, 0);     // corner
        send_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);           // saturation high
        send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_FFFF, 32'h8000_FFFF, 0);           // saturation low
        send_box(5 << 16, 5 << 16, 1, 1, 8 << 16, 8 << 16, 0, 0, 0);                  // inverted box
        send_box(5 << 16, 5 << 16, 1, 1, 5 << 16, 5 << 16, 5 << 16, 5 << 16, 0);      // point box
        send_box(32'h8000_0000, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);                                          // far miss
        drain();

        // radius sweep; phase 1 uses the extremes, upper bits set to be ignored
        write_radius(32'hF000_0000);
        send_box(0, 0, 4, 4, 0, 0, 0, 0, 0);                                           // zero radius, on point
        send_box(1, 0, 4, 4, 0, 0, 0, 0, 0);
        drain();
        write_radius(32'h0FFF_FFFF);
        send_box(32'h8000_0000, 0, 32'h7FFF_FFFF, 9, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send_box(-5, -5, 32'h8000_0000, 9, 0, 0, 10, 10, 0);
        drain();

        for (int i = 0; i < 450; i++) begin
            if (i % 90 == 0) begin
                drain();
                write_radius({4'($urandom_range(0, 15)), 28'd0} | radii[(i / 90) % 4]
                    | (((i / 90) == 4) ? $urandom_range(0, 32'h0FFF_FFFF) : 0));
            end
            if (i == 200) begin
                // hold the sender until every result is back
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk iff pending == 0);
            end
            gap = ((i / 30) % 3 == 0) ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 7) == 0)
                send_item({$urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom(), $urandom()}, gap);
            else
                random_near(gap);
        end
        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/cbcr_pkg.sv
rtl/cbcr_front.sv
rtl/cbcr_sqrt.sv
rtl/cbcr_div.sv
rtl/cbcr_resp.sv
rtl/circle_box_collision_resolve_top.sv
rtl/cbcr_checker.sv
tb/sv/circle_box_collision_resolve_checker.sv
tb/sv/circle_box_collision_resolve_top_tb.sv
